>>> design/cfc_pkg.sv
// Package for the multichannel comb filter: register indexes, fixed-point
// constants and the read-control struct passed from address to datapath.
// No dependencies.
`default_nettype none

package cfc_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int DELAY_W  = 10;
    localparam int FRAC_W   = 14;

    // Configuration register indexes.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_FEEDBACK_MODE = 2'd0;
    localparam cfg_index_t CFG_GAIN          = 2'd1;
    localparam cfg_index_t CFG_DELAY_LENGTH  = 2'd2;

    // Unity gain in Q2.14 and its negative, the clamp limits in feedback mode.
    localparam logic signed [GAIN_W-1:0] GAIN_POS_ONE = 16'sd16384;
    localparam logic signed [GAIN_W-1:0] GAIN_NEG_ONE = -16'sd16384;

    // Saturation limits of a sample.
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    // How the delayed operand of one beat is obtained.
    typedef struct packed {
        logic hit_valid;  // entry was written since the last clear
        logic self_fwd;   // feedforward with zero delay: delayed value is x
    } rd_ctl_t;

endpackage

`default_nettype wire

>>> design/cfc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (read-first on a same-address collision). No dependencies.
`default_nettype none

module cfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the output holds while re is low.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/cfc_addr.sv
// Address unit of the comb filter: per-channel write pointers and wrap
// flags, read position behind the write position, entry-valid check.
// Depends on cfc_pkg.
`default_nettype none

module cfc_addr #(
    parameter int CHANNELS  = 2,
    parameter int MAX_DELAY = 1024,
    parameter int CH_W      = 1,
    parameter int PTR_W     = 10
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           accept,
    input  wire logic                           clear,
    input  wire logic                           channel,
    input  wire logic [cfc_pkg::DELAY_W-1:0]    delay_length,
    input  wire logic                           feedback_mode,
    output logic      [CH_W+PTR_W-1:0]          rd_addr,
    output logic      [CH_W+PTR_W-1:0]          wr_addr,
    output cfc_pkg::rd_ctl_t                    ctl
);

    logic [PTR_W-1:0] ptr_reg  [CHANNELS];
    logic             wrap_reg [CHANNELS];

    logic [CH_W-1:0]  ch_idx;
    logic [PTR_W-1:0] w;
    logic [PTR_W-1:0] d_eff;
    logic [PTR_W-1:0] r;
    logic [PTR_W:0]   diff;
    logic [16:0]      dl_wide;
    logic             last;

    // Line selection, delay clamp and circular read position.
    always_comb begin
        ch_idx  = (CHANNELS > 1) ? CH_W'(channel) : '0;
        w       = ptr_reg[ch_idx];
        dl_wide = 17'(delay_length);
        d_eff   = (dl_wide > 17'(MAX_DELAY - 1)) ? PTR_W'(MAX_DELAY - 1)
                                                : PTR_W'(delay_length);
        diff    = {1'b0, w} - {1'b0, d_eff};
        r       = diff[PTR_W] ? PTR_W'(diff + (PTR_W+1)'(MAX_DELAY))
                              : diff[PTR_W-1:0];
        last    = (w == PTR_W'(MAX_DELAY - 1));

        rd_addr       = {ch_idx, r};
        wr_addr       = {ch_idx, w};
        // An entry holds data once its line has wrapped or it lies behind w.
        ctl.hit_valid = wrap_reg[ch_idx] || (r < w);
        ctl.self_fwd  = !feedback_mode && (d_eff == '0);
    end

    // Pointer advance per accepted beat; reset and delay writes clear lines.
    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            for (int i = 0; i < CHANNELS; i++) begin
                ptr_reg[i]  <= '0;
                wrap_reg[i] <= 1'b0;
            end
        end else if (accept) begin
            ptr_reg[ch_idx] <= last ? '0 : w + 1'b1;
            if (last) begin
                wrap_reg[ch_idx] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/cfc_dp.sv
// Datapath of the comb filter: read-data stage with forwarding, gain
// multiply, shift, saturating add, delay-line write-back and output register.
// Depends on cfc_pkg.
`default_nettype none

module cfc_dp #(
    parameter int ADDR_W = 11
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  accept,
    output logic                                       in_ready,
    input  wire logic                                  in_channel,
    input  wire logic signed [cfc_pkg::SAMPLE_W-1:0]   in_sample,
    input  wire logic                                  in_block_end,
    input  wire logic [ADDR_W-1:0]                     rd_addr,
    input  wire logic [ADDR_W-1:0]                     wr_addr,
    input  wire cfc_pkg::rd_ctl_t                      ctl,
    input  wire logic                                  feedback_mode,
    input  wire logic signed [cfc_pkg::GAIN_W-1:0]     gain,
    input  wire logic [cfc_pkg::SAMPLE_W-1:0]          ram_rdata,
    output logic                                       ram_we,
    output logic      [ADDR_W-1:0]                     ram_waddr,
    output logic      [cfc_pkg::SAMPLE_W-1:0]          ram_wdata,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic                                       m_out_channel,
    output logic signed [cfc_pkg::SAMPLE_W-1:0]        m_out_sample,
    output logic                                       m_out_block_end
);

    // Compute stage registers.
    logic                                  s1_valid_reg;
    logic                                  s1_chan_reg;
    logic signed [cfc_pkg::SAMPLE_W-1:0]   s1_x_reg;
    logic                                  s1_bend_reg;
    logic [ADDR_W-1:0]                     s1_waddr_reg;
    cfc_pkg::rd_ctl_t                      s1_ctl_reg;
    logic                                  fwd_hit_reg;
    logic signed [cfc_pkg::SAMPLE_W-1:0]   fwd_data_reg;

    // Output registers.
    logic                                  m_valid_reg;
    logic                                  m_chan_reg;
    logic signed [cfc_pkg::SAMPLE_W-1:0]   m_sample_reg;
    logic                                  m_bend_reg;

    logic                                  out_free;
    logic                                  s1_fire;
    logic signed [cfc_pkg::GAIN_W-1:0]     gain_eff;
    logic signed [cfc_pkg::SAMPLE_W-1:0]   delayed;
    logic signed [31:0]                    prod;
    logic signed [17:0]                    prod_sh;
    logic signed [17:0]                    sum;
    logic signed [cfc_pkg::SAMPLE_W-1:0]   y;
    logic signed [cfc_pkg::SAMPLE_W-1:0]   wdata;

    // Handshake: the compute stage moves whenever the output register frees.
    assign out_free = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    // Delayed operand, gain clamp, multiply, floor shift and saturating add.
    always_comb begin
        if (s1_ctl_reg.self_fwd) begin
            delayed = s1_x_reg;
        end else if (fwd_hit_reg) begin
            delayed = fwd_data_reg;
        end else if (s1_ctl_reg.hit_valid) begin
            delayed = ram_rdata;
        end else begin
            delayed = '0;
        end

        gain_eff = gain;
        if (feedback_mode) begin
            if (gain > cfc_pkg::GAIN_POS_ONE) begin
                gain_eff = cfc_pkg::GAIN_POS_ONE;
            end else if (gain < cfc_pkg::GAIN_NEG_ONE) begin
                gain_eff = cfc_pkg::GAIN_NEG_ONE;
            end
        end

        prod    = gain_eff * delayed;
        prod_sh = prod[31:cfc_pkg::FRAC_W];
        sum     = 18'(s1_x_reg) + prod_sh;

        if (sum > 18'(cfc_pkg::SAMPLE_MAX)) begin
            y = cfc_pkg::SAMPLE_MAX;
        end else if (sum < 18'(cfc_pkg::SAMPLE_MIN)) begin
            y = cfc_pkg::SAMPLE_MIN;
        end else begin
            y = sum[cfc_pkg::SAMPLE_W-1:0];
        end

        // Feedback stores the result, feedforward stores the input.
        wdata = feedback_mode ? y : s1_x_reg;
    end

    assign ram_we    = s1_fire;
    assign ram_waddr = s1_waddr_reg;
    assign ram_wdata = wdata;

    // Compute stage valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Compute stage payload. A read that collides with the write-back of
    // the beat ahead takes its data from the forwarding register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_chan_reg  <= in_channel;
            s1_x_reg     <= in_sample;
            s1_bend_reg  <= in_block_end;
            s1_waddr_reg <= wr_addr;
            s1_ctl_reg   <= ctl;
            fwd_hit_reg  <= s1_valid_reg && (rd_addr == s1_waddr_reg);
            fwd_data_reg <= wdata;
        end
    end

    // Output register valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_chan_reg   <= s1_chan_reg;
            m_sample_reg <= y;
            m_bend_reg   <= s1_bend_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_channel   = m_chan_reg;
    assign m_out_sample    = m_sample_reg;
    assign m_out_block_end = m_bend_reg;

endmodule

`default_nettype wire

>>> design/comb_filter_fir_iir_top.sv
// Top level of the multichannel feedforward/feedback comb filter.
// Depends on cfc_pkg, cfc_ram, cfc_addr and cfc_dp.
//
//   Channel   Direction  Beat contents
//   s_        in         channel, input sample, block-end mark
//   m_        out        channel, filtered sample, block-end mark
//   cfg_      in         register index, write data
//
// One beat per cycle is accepted while the output is not stalled.
// The delay line is one RAM with a registered read: the read is
// issued at acceptance and the write-back happens in the compute stage, with
// the beat ahead forwarded on a same-entry collision.
// Reset and delay-length writes clear the pointers and wrap flags at once;
// entries not yet written read as zero, so no clearing pass is needed.
// A stalled output holds the compute stage, and the input waits behind it.
`default_nettype none

module comb_filter_fir_iir_top #(
    parameter int CHANNELS  = 2,
    parameter int MAX_DELAY = 1024
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_channel,
    input  wire logic signed [cfc_pkg::SAMPLE_W-1:0]  s_in_sample,
    input  wire logic                                 s_block_end,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_out_channel,
    output logic signed [cfc_pkg::SAMPLE_W-1:0]       m_out_sample,
    output logic                                      m_out_block_end,

    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire cfc_pkg::cfg_index_t                  cfg_index,
    input  wire logic [15:0]                          cfg_data
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PTR_W  = $clog2(MAX_DELAY);
    localparam int ADDR_W = CH_W + PTR_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    logic                                 mode_reg;
    logic signed [cfc_pkg::GAIN_W-1:0]    gain_reg;
    logic [cfc_pkg::DELAY_W-1:0]          delay_reg;

    logic                                 accept;
    logic                                 delay_clear;
    logic [ADDR_W-1:0]                    rd_addr;
    logic [ADDR_W-1:0]                    wr_addr;
    cfc_pkg::rd_ctl_t                     ctl;
    logic [cfc_pkg::SAMPLE_W-1:0]         ram_rdata;
    logic                                 ram_we;
    logic [ADDR_W-1:0]                    ram_waddr;
    logic [cfc_pkg::SAMPLE_W-1:0]         ram_wdata;

    assign cfg_ready   = 1'b1;
    assign accept      = s_valid && s_ready;
    assign delay_clear = cfg_valid && (cfg_index == cfc_pkg::CFG_DELAY_LENGTH);

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            gain_reg  <= '0;
            delay_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cfc_pkg::CFG_FEEDBACK_MODE: mode_reg  <= cfg_data[0];
                cfc_pkg::CFG_GAIN:          gain_reg  <= cfg_data;
                cfc_pkg::CFG_DELAY_LENGTH:  delay_reg <= cfg_data[cfc_pkg::DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Pointers and read position.
    cfc_addr #(
        .CHANNELS (CHANNELS),
        .MAX_DELAY(MAX_DELAY),
        .CH_W     (CH_W),
        .PTR_W    (PTR_W)
    ) u_addr (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .clear        (delay_clear),
        .channel      (s_channel),
        .delay_length (delay_reg),
        .feedback_mode(mode_reg),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .ctl          (ctl)
    );

    // Delay-line storage for all channels.
    cfc_ram #(
        .WIDTH(cfc_pkg::SAMPLE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (accept),
        .raddr(rd_addr),
        .rdata(ram_rdata)
    );

    // Arithmetic, write-back and output register.
    cfc_dp #(
        .ADDR_W(ADDR_W)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .in_ready       (s_ready),
        .in_channel     (s_channel),
        .in_sample      (s_in_sample),
        .in_block_end   (s_block_end),
        .rd_addr        (rd_addr),
        .wr_addr        (wr_addr),
        .ctl            (ctl),
        .feedback_mode  (mode_reg),
        .gain           (gain_reg),
        .ram_rdata      (ram_rdata),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_channel  (m_out_channel),
        .m_out_sample   (m_out_sample),
        .m_out_block_end(m_out_block_end)
    );

`ifndef SYNTHESIS
    // With the output register empty, nothing can hold the input back.
    a_ready_when_out_empty: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready
    ) else $error("input not ready while the output register is empty");

    // An accepted beat reaches the output once the output side frees.
    a_beat_reaches_output: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 (!m_valid || m_ready) |=> m_valid
    ) else $error("accepted beat did not reach the output register");

    // A stalled result blocks the input only when the compute stage is full.
    a_stall_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 (m_valid && !m_ready) |-> !s_ready
    ) else $error("input accepted over a full compute stage");
`endif

endmodule

`default_nettype wire
